/* hw/rtl/u8d_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8d_pkg;

    localparam int C_DEPTH   = 5;
    localparam int C_MAX_RES = 6;
    localparam int C_QDEPTH  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic [30:0] code_point;
        logic        invalid;
        logic        run_last;
        logic        line_done;
    } t_out_word;

    typedef struct packed {
        logic [C_MAX_RES-1:0][7:0] inv_bytes;
        logic [2:0]                n_inv;
        logic                      has_valid;
        logic [30:0]               code_point;
        logic                      line_end;
    } t_job;

endpackage
`default_nettype wire

/* hw/rtl/u8d_front.sv */
// Front end: sequence state, byte classification and job building.
`timescale 1ns / 1ps
`default_nettype none
module u8d_front
    import u8d_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_word i_word,
    output t_job          o_job,
    output logic          o_job_valid
);

    localparam logic [30:0] C_LIM1 = 31'h0000007f;
    localparam logic [30:0] C_LIM2 = 31'h000007ff;
    localparam logic [30:0] C_LIM3 = 31'h0000ffff;
    localparam logic [30:0] C_LIM4 = 31'h001fffff;
    localparam logic [30:0] C_LIM5 = 31'h03ffffff;

    function automatic logic [2:0] min_len(input logic [30:0] v);
        logic [2:0] r;
        if (v <= C_LIM1) r = 3'd1;
        else if (v <= C_LIM2) r = 3'd2;
        else if (v <= C_LIM3) r = 3'd3;
        else if (v <= C_LIM4) r = 3'd4;
        else if (v <= C_LIM5) r = 3'd5;
        else r = 3'd6;
        return r;
    endfunction

    logic [7:0]  r_pend [C_DEPTH];
    logic [2:0]  r_pend_cnt, n_pend_cnt;
    logic [2:0]  r_exp_len,  n_exp_len;
    logic [30:0] r_part,     n_part;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [7:0]  b;
    logic        le;
    logic        is_cont;
    logic [30:0] v;
    logic [2:0]  plus1;
    logic [2:0]  lead_len;
    logic [30:0] lead_bits;
    t_job        job;

    assign b       = i_word.data_byte;
    assign le      = i_word.line_end;
    assign is_cont = (b[7:6] == 2'b10);
    assign v       = {r_part[24:0], b[5:0]};
    assign plus1   = 3'(r_pend_cnt + 3'd1);

    always_comb begin
        lead_len  = 3'd0;
        lead_bits = '0;
        if (b[7:5] == 3'b110) begin
            lead_len  = 3'd2;
            lead_bits = {26'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            lead_len  = 3'd3;
            lead_bits = {27'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            lead_len  = 3'd4;
            lead_bits = {28'd0, b[2:0]};
        end else if (b[7:2] == 6'b111110) begin
            lead_len  = 3'd5;
            lead_bits = {29'd0, b[1:0]};
        end else if (b[7:1] == 7'b1111110) begin
            lead_len  = 3'd6;
            lead_bits = {30'd0, b[0]};
        end
    end

    always_comb begin
        n_pend_cnt = r_pend_cnt;
        n_exp_len  = r_exp_len;
        n_part     = r_part;
        wr_en      = 1'b0;
        wr_idx     = r_pend_cnt;
        job        = '0;
        job.line_end = le;
        for (int i = 0; i < C_DEPTH; i++) begin
            job.inv_bytes[i] = (3'(i) < r_pend_cnt) ? r_pend[i] : b;
        end
        job.inv_bytes[C_MAX_RES-1] = b;

        if (r_pend_cnt != 3'd0 && is_cont) begin
            if (plus1 >= r_exp_len) begin
                if (min_len(v) == r_exp_len) begin
                    job.has_valid  = 1'b1;
                    job.code_point = v;
                end else begin
                    job.n_inv = plus1;
                end
                n_pend_cnt = 3'd0;
                n_exp_len  = 3'd0;
                n_part     = '0;
            end else if (r_pend_cnt < 3'(C_DEPTH)) begin
                if (le) begin
                    job.n_inv  = plus1;
                    n_pend_cnt = 3'd0;
                    n_exp_len  = 3'd0;
                    n_part     = '0;
                end else begin
                    wr_en      = 1'b1;
                    n_pend_cnt = plus1;
                    n_part     = v;
                end
            end else begin
                job.n_inv  = plus1;
                n_pend_cnt = 3'd0;
                n_exp_len  = 3'd0;
                n_part     = '0;
            end
        end else begin
            job.n_inv  = r_pend_cnt;
            n_pend_cnt = 3'd0;
            n_exp_len  = 3'd0;
            n_part     = '0;
            if (!b[7]) begin
                job.has_valid  = 1'b1;
                job.code_point = {23'd0, b};
            end else if (lead_len == 3'd0) begin
                job.n_inv = plus1;
            end else if (le) begin
                job.n_inv = plus1;
            end else begin
                wr_en      = 1'b1;
                wr_idx     = 3'd0;
                n_pend_cnt = 3'd1;
                n_exp_len  = lead_len;
                n_part     = lead_bits;
            end
        end
    end

    assign o_job       = job;
    assign o_job_valid = i_accept && (job.n_inv != 3'd0 || job.has_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 3'd0;
            r_exp_len  <= 3'd0;
            r_part     <= '0;
        end else if (i_accept) begin
            r_pend_cnt <= n_pend_cnt;
            r_exp_len  <= n_exp_len;
            r_part     <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_pend[wr_idx] <= b;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt <= 3'(C_DEPTH))
        else $error("pending count out of range");
    a_open_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 3'd0 |-> r_exp_len > r_pend_cnt)
        else $error("open sequence already complete");
    a_idle_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt == 3'd0 |-> (r_exp_len == 3'd0 && r_part == '0))
        else $error("sequence state not cleared");
`endif

endmodule
`default_nettype wire

/* hw/rtl/u8d_fifo.sv */
// Short job queue between front end and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module u8d_fifo
    import u8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_data,
    input  wire logic i_rd,
    output t_job      o_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int C_PW = $clog2(C_QDEPTH);

    t_job            r_mem [C_QDEPTH];
    logic [C_PW-1:0] r_wr_ptr;
    logic [C_PW-1:0] r_rd_ptr;
    logic [C_PW:0]   r_count;

    assign o_full  = (r_count == (C_PW+1)'(C_QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= C_PW'(r_wr_ptr + 1'b1);
            end
            if (i_rd) begin
                r_rd_ptr <= C_PW'(r_rd_ptr + 1'b1);
            end
            if (i_wr && !i_rd) begin
                r_count <= (C_PW+1)'(r_count + 1'b1);
            end else if (!i_wr && i_rd) begin
                r_count <= (C_PW+1)'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/u8d_back.sv */
// Result sequencer: walks one queued job, one result word per pop.
`timescale 1ns / 1ps
`default_nettype none
module u8d_back
    import u8d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_empty,
    output logic      o_job_done,
    input  wire logic i_pop,
    output t_out_word o_word
);

    logic [2:0] r_idx;
    logic [2:0] total;
    logic       last;
    logic [7:0] inv_byte;

    assign total = 3'(i_job.n_inv + {2'd0, i_job.has_valid});
    assign last  = (r_idx == 3'(total - 3'd1));

    always_comb begin
        case (r_idx)
            3'd0:    inv_byte = i_job.inv_bytes[0];
            3'd1:    inv_byte = i_job.inv_bytes[1];
            3'd2:    inv_byte = i_job.inv_bytes[2];
            3'd3:    inv_byte = i_job.inv_bytes[3];
            3'd4:    inv_byte = i_job.inv_bytes[4];
            3'd5:    inv_byte = i_job.inv_bytes[5];
            default: inv_byte = '0;
        endcase
    end

    always_comb begin
        o_word = '0;
        if (r_idx < i_job.n_inv) begin
            o_word.code_point = {23'd0, inv_byte};
            o_word.invalid    = 1'b1;
        end else begin
            o_word.code_point = i_job.code_point;
        end
        o_word.run_last  = last;
        o_word.line_done = last && i_job.line_end;
    end

    assign o_job_done = i_pop && !i_job_empty && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (i_pop && !i_job_empty) begin
            r_idx <= last ? 3'd0 : 3'(r_idx + 3'd1);
        end
    end

`ifndef SYNTHESIS
    a_job_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_empty |-> (total != 3'd0 && total <= 3'(C_MAX_RES) && r_idx < total))
        else $error("job result count out of range");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_empty |-> r_idx == 3'd0)
        else $error("result index left over with no job");
`endif

endmodule
`default_nettype wire

/* hw/rtl/utf8_stream_decoder.sv */
// Top level of the six-byte UTF-8 stream decoder.
//
//  channel  | handshake        | word
//  ---------+------------------+------------------------------------------
//  input    | push / full      | t_in_word: data_byte, line_end
//  result   | empty / pop      | t_out_word: code_point, invalid, run_last,
//           |                  |             line_done
//
// One byte accepted per cycle while full is low; its sequence state
// updates in the same cycle. Each byte leaves 0 to 6 result words; the
// sequencer gives one word per cycle while pop is high and empty is low.
// A two-entry job queue separates the two sides; full rises when it holds
// two jobs whose words are not all taken.
// Reset is synchronous and clears sequence state and queue pointers.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_word i_in_word,
    output logic          empty,
    input  wire logic     pop,
    output t_out_word     o_out_word
);

    logic accept;
    t_job front_job;
    logic front_job_valid;
    t_job head_job;
    logic job_empty;
    logic job_done;

    assign accept = push && !full;
    assign empty  = job_empty;

    u8d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .o_job       (front_job),
        .o_job_valid (front_job_valid)
    );

    u8d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_job_valid),
        .i_data  (front_job),
        .i_rd    (job_done),
        .o_data  (head_job),
        .o_full  (full),
        .o_empty (job_empty)
    );

    u8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (job_empty),
        .o_job_done  (job_done),
        .i_pop       (pop),
        .o_word      (o_out_word)
    );

endmodule
`default_nettype wire
